// ----- hdl/wplc_pkg.sv -----
// Shared types, codes and constants of the water pump level controller.
package wplc_pkg;

  // Button codes carried in the action field; other codes mean no button
  localparam logic [2:0] ActNone = 3'd0;
  localparam logic [2:0] ActMenu = 3'd1;
  localparam logic [2:0] ActDown = 3'd2;
  localparam logic [2:0] ActUp   = 3'd3;
  localparam logic [2:0] ActPump = 3'd4;

  typedef enum logic [1:0] {
    MENU_DIST = 2'd0,
    MENU_AUTO = 2'd1,
    MENU_MIN  = 2'd2,
    MENU_MAX  = 2'd3
  } menu_e;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgMinFloor   = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgMaxCeiling = 1'b1;

  // Reset values
  localparam logic [7:0] MinFloorRst = 8'd5;
  localparam logic [7:0] MaxCeilRst  = 8'd15;
  localparam logic [7:0] MinLevelRst = 8'd15;
  localparam logic [7:0] MaxLevelRst = 8'd5;

  // cm = floor(ticks*5/2328) = floor(floor(ticks*5/8) / 291);
  // the divide by 291 is exact for 16-bit dividends as (y * 57654) >> 24
  localparam logic [15:0] RecipMul   = 16'd57654;
  localparam int unsigned RecipShift = 24;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] echo_ticks;
    logic        echo_timed_out;
  } item_t;

  typedef struct packed {
    logic       pump_on;
    logic [7:0] level_cm;
    menu_e      menu_mode;
    logic       auto_on;
    logic [7:0] min_level;
    logic [7:0] max_level;
  } result_t;

endpackage

// ----- hdl/water_pump_level_controller_top.sv -----
// Top level of the water pump level controller: input register, control core, result word.
//
// Each accepted input word is one pass of the control loop and yields one result word.
// The block accepts one word per cycle unless the result word stalls; the input register
// feeds the echo conversion (one 16x16 multiply) and the menu/pump update, which commit
// into the state registers that also form the result word. The result word holds while
// the downstream stalls, and one further input word is taken into the input register
// meanwhile. Configuration writes take effect on the next cycle.
module water_pump_level_controller_top import wplc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [15:0]        s_axis_tdata,  // [15:0] echo_ticks
  input  logic [3:0]         s_axis_tuser,  // [2:0] action, [3] echo_timed_out
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // [0] pump_on, [8:1] level_cm, [10:9] menu_mode, [11] auto_on,
  // [19:12] min_level, [27:20] max_level, [31:28] zero
  output logic [31:0]        m_axis_tdata,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [7:0]         cfg_wdata_i
);

  logic    in_valid_q, in_valid_d;
  item_t   in_item_q;
  logic    out_valid_q, out_valid_d;
  logic    advance;
  logic [7:0] meas_cm;
  result_t state;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tready) in_valid_d = s_axis_tvalid;
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload register, loaded on every accepted word
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q.action         <= s_axis_tuser[2:0];
      in_item_q.echo_ticks     <= s_axis_tdata;
      in_item_q.echo_timed_out <= s_axis_tuser[3];
    end
  end

  wplc_dist u_dist (
    .echo_ticks_i     (in_item_q.echo_ticks),
    .echo_timed_out_i (in_item_q.echo_timed_out),
    .level_cm_o       (meas_cm)
  );

  wplc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (advance),
    .item_i      (in_item_q),
    .meas_cm_i   (meas_cm),
    .state_o     (state)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, state.max_level, state.min_level, state.auto_on,
                          state.menu_mode, state.level_cm, state.pump_on};

endmodule

// ----- hdl/wplc_dist.sv -----
// Echo length to centimetre conversion by constant reciprocal multiply.
module wplc_dist import wplc_pkg::*; (
  input  logic [15:0] echo_ticks_i,
  input  logic        echo_timed_out_i,
  output logic [7:0]  level_cm_o
);

  logic [18:0] ticks_x5;
  logic [15:0] ticks_div8;
  logic [31:0] prod;

  assign ticks_x5   = {1'b0, echo_ticks_i, 2'b00} + {3'b000, echo_ticks_i};
  assign ticks_div8 = ticks_x5[18:3];
  assign prod       = {16'd0, ticks_div8} * {16'd0, RecipMul};

  // quotient never exceeds 140, so eight bits above the shift hold it
  assign level_cm_o = echo_timed_out_i ? 8'd0 : prod[RecipShift +: 8];

endmodule

// ----- hdl/wplc_ctrl.sv -----
// Menu, threshold and pump state with their per-item update logic.
module wplc_ctrl import wplc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic               step_i,
  input  item_t              item_i,
  input  logic [7:0]         meas_cm_i,
  output result_t            state_o
);

  logic [7:0] min_floor_q, max_ceiling_q;
  result_t    state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_floor_q   <= MinFloorRst;
      max_ceiling_q <= MaxCeilRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMinFloor:   min_floor_q   <= cfg_wdata_i;
        CfgMaxCeiling: max_ceiling_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [2:0] act;
    act     = item_i.action;
    state_d = state_q;

    if (act == ActMenu) begin
      state_d.menu_mode = menu_e'(state_q.menu_mode + 2'd1);
    end

    unique case (state_d.menu_mode)
      MENU_DIST: state_d.level_cm = meas_cm_i;
      MENU_AUTO: begin
        if (act == ActDown) state_d.auto_on = ~state_q.auto_on;
      end
      MENU_MIN: begin
        if (act == ActDown) begin
          if (state_q.min_level > min_floor_q) state_d.min_level = state_q.min_level - 8'd1;
        end else if (act == ActUp) begin
          if (state_q.min_level != 8'hFF) state_d.min_level = state_q.min_level + 8'd1;
        end
      end
      MENU_MAX: begin
        if (act == ActDown) begin
          if (state_q.max_level != 8'd0) state_d.max_level = state_q.max_level - 8'd1;
        end else if (act == ActUp) begin
          if (state_q.max_level < max_ceiling_q) state_d.max_level = state_q.max_level + 8'd1;
        end
      end
      default: ;
    endcase

    // pump uses the freshly updated level and thresholds
    if (state_d.auto_on) begin
      if (state_d.level_cm >= state_d.min_level) begin
        state_d.pump_on = 1'b1;
      end else if (state_d.level_cm <= state_d.max_level) begin
        state_d.pump_on = 1'b0;
      end
    end else begin
      if (act == ActPump) state_d.pump_on = ~state_q.pump_on;
      if (state_d.level_cm <= state_d.max_level) state_d.pump_on = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.pump_on   <= 1'b0;
      state_q.level_cm  <= 8'd0;
      state_q.menu_mode <= MENU_DIST;
      state_q.auto_on   <= 1'b0;
      state_q.min_level <= MinLevelRst;
      state_q.max_level <= MaxLevelRst;
    end else if (step_i) begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

// ----- hdl/wplc_checker.sv -----
// Port-level checks of the water pump level controller, bound to the top level.
module wplc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  logic       pump_on, auto_on;
  logic [7:0] level_cm, min_level, max_level;

  assign pump_on   = m_axis_tdata[0];
  assign level_cm  = m_axis_tdata[8:1];
  assign auto_on   = m_axis_tdata[11];
  assign min_level = m_axis_tdata[19:12];
  assign max_level = m_axis_tdata[27:20];

  // manual mode never leaves the pump on at or below the cut-off
  a_manual_cutoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !auto_on && pump_on) |-> (level_cm > max_level))
    else $error("pump on in manual mode at or below max level");

  // a running pump is always above the cut-off or at/above the switch-on level
  a_pump_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && pump_on) |-> (level_cm > max_level || level_cm >= min_level))
    else $error("pump on without reason");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (level_cm <= 8'd140))
    else $error("distance out of range");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result word changed while stalled");

endmodule

bind water_pump_level_controller_top wplc_checker u_wplc_checker (.*);
